@@ rtl/gbs_pkg.sv @@
// Shared types and constants for the greedy box suppression block.
package gbs_pkg;

	localparam int MAX_KEPT   = 64;
	localparam int INDEX_BITS = 13;
	localparam int CNT_W      = $clog2(MAX_KEPT + 1);
	localparam logic [15:0] THR_RESET = 16'd29491;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [15:0]        w;
		logic [15:0]        h;
	} box_t;

	typedef struct packed {
		logic               frame_start;
		logic signed [15:0] box_x;
		logic signed [15:0] box_y;
		logic [15:0]        box_w;
		logic [15:0]        box_h;
	} req_t;

	typedef struct packed {
		logic                  keep;
		logic [INDEX_BITS-1:0] box_index;
		logic                  store_full;
	} res_t;

	typedef struct packed {
		logic shift;
		logic tail;
		logic load;
	} cell_ctl_t;

	typedef struct packed {
		logic hit;
		logic busy;
	} iou_stat_t;

endpackage

@@ rtl/gbs_cell.sv @@
// One kept-box cell of the rotating store.
module gbs_cell (
	input  logic                clk,
	input  gbs_pkg::cell_ctl_t  ctl,
	input  gbs_pkg::box_t       next_box,
	input  gbs_pkg::box_t       head_box,
	input  gbs_pkg::box_t       new_box,
	output gbs_pkg::box_t       box
);

	gbs_pkg::box_t box_q;

	// The tail cell closes the ring by taking the head's box.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			box_q <= new_box;
		end else if (ctl.shift) begin
			box_q <= ctl.tail ? head_box : next_box;
		end
	end

	assign box = box_q;

endmodule

@@ rtl/gbs_iou.sv @@
// Pipelined overlap test: intersection * 65536 > threshold * union.
module gbs_iou (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	input  gbs_pkg::box_t       box_a,
	input  logic [31:0]         area_a,
	input  gbs_pkg::box_t       box_b,
	input  logic [15:0]         threshold,
	output gbs_pkg::iou_stat_t  stat
);

	logic               v_s1, v_s2, v_s3, v_s4;
	logic [15:0]        iw_s1, ih_s1, bw_s1, bh_s1;
	logic [31:0]        inter_s2, areab_s2;
	logic [31:0]        inter_s3;
	logic [32:0]        uni_s3;
	logic [31:0]        inter_s4;
	logic [48:0]        prod_s4;
	logic               nz_s4;

	logic signed [17:0] lo_x, lo_y, hi_x, hi_y, ae_x, be_x, ae_y, be_y, dx, dy;
	logic [15:0]        iw, ih;
	logic [48:0]        lhs;

	always_comb begin
		ae_x = 18'(box_a.x) + $signed({2'b00, box_a.w});
		be_x = 18'(box_b.x) + $signed({2'b00, box_b.w});
		ae_y = 18'(box_a.y) + $signed({2'b00, box_a.h});
		be_y = 18'(box_b.y) + $signed({2'b00, box_b.h});
		lo_x = (box_a.x > box_b.x) ? 18'(box_a.x) : 18'(box_b.x);
		lo_y = (box_a.y > box_b.y) ? 18'(box_a.y) : 18'(box_b.y);
		hi_x = (ae_x < be_x) ? ae_x : be_x;
		hi_y = (ae_y < be_y) ? ae_y : be_y;
		dx   = hi_x - lo_x;
		dy   = hi_y - lo_y;
		// A positive overlap never exceeds the narrower extent, so 16 bits hold it.
		iw   = (dx > 18'sd0) ? dx[15:0] : 16'd0;
		ih   = (dy > 18'sd0) ? dy[15:0] : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		iw_s1     <= iw;
		ih_s1     <= ih;
		bw_s1     <= box_b.w;
		bh_s1     <= box_b.h;
		inter_s2  <= 32'(iw_s1) * 32'(ih_s1);
		areab_s2  <= 32'(bw_s1) * 32'(bh_s1);
		inter_s3  <= inter_s2;
		uni_s3    <= {1'b0, area_a} + {1'b0, areab_s2} - {1'b0, inter_s2};
		inter_s4  <= inter_s3;
		prod_s4   <= 49'(threshold) * 49'(uni_s3);
		nz_s4     <= (uni_s3 != 33'd0);
	end

	assign lhs       = {1'b0, inter_s4, 16'd0};
	assign stat.hit  = v_s4 && nz_s4 && (lhs > prod_s4);
	assign stat.busy = v_s1 || v_s2 || v_s3 || v_s4;

endmodule

@@ rtl/greedy_box_suppression.sv @@
// Top level: greedy box suppression over a rotating ring of kept-box cells.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------
//  box      | box_valid / box_stall      | gbs_pkg::req_t (frame flag, box)
//  result   | result_valid / result_stall| gbs_pkg::res_t (keep, index, full)
//  cfg      | cfg_valid / cfg_ready      | cfg_data, overlap threshold Q0.16
//
// Between a request's acceptance and its result being registered, the kept
// boxes rotate once round the ring, one a cycle, past a single four-stage
// overlap unit, which then drains.
// The next request can be taken in the cycle after the result is registered.
// Reset empties the store, zeroes the index and loads the default threshold.
// A stalled result holds its register; the next request is still taken and
// waits before its write-back until the result register frees.
module greedy_box_suppression (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            box_valid,
	output logic            box_stall,
	input  gbs_pkg::req_t   box,
	output logic            result_valid,
	input  logic            result_stall,
	output gbs_pkg::res_t   result,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [15:0]     cfg_data
);

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} state_t;

	localparam logic [gbs_pkg::INDEX_BITS-1:0] IDX_MAX = {gbs_pkg::INDEX_BITS{1'b1}};
	localparam logic [gbs_pkg::CNT_W-1:0] CNT_FULL = gbs_pkg::CNT_W'(gbs_pkg::MAX_KEPT);

	state_t                           state_q;
	logic [15:0]                      thr_q;
	logic [gbs_pkg::CNT_W-1:0]        cnt_q, iss_q, tail_idx;
	logic [gbs_pkg::INDEX_BITS-1:0]   seen_q, base_idx, idx_q;
	logic                             sup_q, res_valid_q;
	gbs_pkg::res_t                    res_q;
	gbs_pkg::box_t                    cur_q;
	logic [31:0]                      area_q;

	logic                             accept, issue, fin_go, keep_w, full_w, wr;
	gbs_pkg::iou_stat_t               stat;
	gbs_pkg::box_t                    cells [gbs_pkg::MAX_KEPT];
	gbs_pkg::box_t                    new_box;

	assign box_stall = (state_q != S_IDLE);
	assign accept    = box_valid && !box_stall;
	assign issue     = (state_q == S_RUN) && (iss_q != cnt_q);
	assign fin_go    = (state_q == S_FIN) && (!res_valid_q || !result_stall);
	assign keep_w    = !sup_q;
	assign full_w    = keep_w && (cnt_q == CNT_FULL);
	assign wr        = fin_go && keep_w && !full_w;
	assign tail_idx  = cnt_q - gbs_pkg::CNT_W'(1);
	assign base_idx  = box.frame_start ? '0 : seen_q;
	assign new_box   = cur_q;

	assign cfg_ready    = 1'b1;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// Hold the request's box and its own area for the whole pass.
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q.x <= box.box_x;
			cur_q.y <= box.box_y;
			cur_q.w <= box.box_w;
			cur_q.h <= box.box_h;
			area_q  <= 32'(box.box_w) * 32'(box.box_h);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			thr_q       <= gbs_pkg::THR_RESET;
			cnt_q       <= '0;
			seen_q      <= '0;
			idx_q       <= '0;
			iss_q       <= '0;
			sup_q       <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (cfg_valid) begin
				thr_q <= cfg_data;
			end
			if (fin_go) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (box.frame_start) begin
							cnt_q <= '0;
						end
						idx_q  <= base_idx;
						seen_q <= (base_idx == IDX_MAX) ? base_idx
							: base_idx + gbs_pkg::INDEX_BITS'(1);
						iss_q   <= '0;
						sup_q   <= 1'b0;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (issue) begin
						iss_q <= iss_q + gbs_pkg::CNT_W'(1);
					end
					if (stat.hit) begin
						sup_q <= 1'b1;
					end
					// Advance once every stored box has gone round and the unit is empty.
					if (!issue && !stat.busy) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						res_q.keep       <= keep_w;
						res_q.box_index  <= idx_q;
						res_q.store_full <= full_w;
						if (wr) begin
							cnt_q <= cnt_q + gbs_pkg::CNT_W'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	for (genvar i = 0; i < gbs_pkg::MAX_KEPT; i++) begin : g_cell
		gbs_pkg::cell_ctl_t ctl;
		gbs_pkg::box_t      nxt;

		assign ctl.shift = issue;
		assign ctl.tail  = (tail_idx == gbs_pkg::CNT_W'(i));
		assign ctl.load  = wr && (cnt_q == gbs_pkg::CNT_W'(i));
		assign nxt       = cells[(i + 1) % gbs_pkg::MAX_KEPT];

		gbs_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.next_box (nxt),
			.head_box (cells[0]),
			.new_box  (new_box),
			.box      (cells[i])
		);
	end

	gbs_iou u_iou (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (issue),
		.box_a     (cur_q),
		.area_a    (area_q),
		.box_b     (cells[0]),
		.threshold (thr_q),
		.stat      (stat)
	);

endmodule

@@ tb/tb_greedy_box_suppression.sv @@
// Testbench for greedy_box_suppression: directed and random box streams, self-checked.
`timescale 1ns / 1ps

module tb_greedy_box_suppression;
	import gbs_pkg::*;

	localparam int IDX_MAX    = (1 << INDEX_BITS) - 1;
	localparam int STUCK_MAX  = 2000;
	localparam int END_PAUSE  = MAX_KEPT + 16;
	localparam int REPORT_MAX = 10;

	logic        clk;
	logic        arst_n;
	logic        box_valid;
	logic        box_stall;
	req_t        box;
	logic        result_valid;
	logic        result_stall;
	res_t        result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	// Predictor state
	longint      held_x [MAX_KEPT];
	longint      held_y [MAX_KEPT];
	longint      held_w [MAX_KEPT];
	longint      held_h [MAX_KEPT];
	int          held_n;
	int          next_index;
	logic [15:0] thr_q16;

	res_t        verdict_q [$];
	int          fail_count;
	int          tx_quiet;
	int          rx_quiet;
	int          stuck_cycles;

	greedy_box_suppression u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.box_valid    (box_valid),
		.box_stall    (box_stall),
		.box          (box),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Idle for a while now and then, with quiet stretches of back-to-back traffic
	function automatic int draw_wait(inout int quiet_left);
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			quiet_left = $urandom_range(20, 60);
			return 0;
		end
		return $urandom_range(0, 11);
	endfunction

	function automatic req_t make_req(input bit fs, input int x, input int y, input int w,
			input int h);
		req_t r;
		r.frame_start = fs;
		r.box_x       = 16'(x);
		r.box_y       = 16'(y);
		r.box_w       = 16'(w);
		r.box_h       = 16'(h);
		return r;
	endfunction

	function automatic longint span_overlap(input longint a0, input longint al,
			input longint b0, input longint bl);
		longint lo;
		longint hi;
		lo = (a0 > b0) ? a0 : b0;
		hi = (a0 + al < b0 + bl) ? a0 + al : b0 + bl;
		return (hi > lo) ? hi - lo : 0;
	endfunction

	// Greedy suppression against every box held in the current frame
	function automatic res_t predict_verdict(input req_t r);
		res_t   v;
		longint bx, by, bw, bh;
		longint inter, uni;
		bit     keep;
		int     k;
		bx = longint'($signed(r.box_x));
		by = longint'($signed(r.box_y));
		bw = longint'(r.box_w);
		bh = longint'(r.box_h);
		if (r.frame_start) begin
			held_n     = 0;
			next_index = 0;
		end
		v.box_index = next_index[INDEX_BITS-1:0];
		if (next_index < IDX_MAX)
			next_index++;
		keep = 1'b1;
		for (k = 0; k < held_n; k++) begin
			inter = span_overlap(bx, bw, held_x[k], held_w[k]) *
				span_overlap(by, bh, held_y[k], held_h[k]);
			uni = bw * bh + held_w[k] * held_h[k] - inter;
			if (uni != 0 && (inter << 16) > longint'(thr_q16) * uni)
				keep = 1'b0;
		end
		v.keep       = keep;
		v.store_full = 1'b0;
		if (keep) begin
			if (held_n < MAX_KEPT) begin
				held_x[held_n] = bx;
				held_y[held_n] = by;
				held_w[held_n] = bw;
				held_h[held_n] = bh;
				held_n++;
			end else begin
				v.store_full = 1'b1;
			end
		end
		return v;
	endfunction

	task automatic send_box(input req_t r);
		int gap;
		gap = draw_wait(tx_quiet);
		if (gap > 0) begin
			box_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		box_valid <= 1'b1;
		box       <= r;
		do @(posedge clk); while (box_stall);
		verdict_q = {verdict_q, predict_verdict(r)};
	endtask

	// Drop valid and wait until every request has its result
	task automatic settle();
		box_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_threshold(input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		thr_q16 = value;
	endtask

	task automatic test_default_threshold();
		send_box(make_req(1, 0, 0, 160, 160));
		send_box(make_req(0, 0, 0, 160, 160));          // identical, suppress
		send_box(make_req(0, -32768, -32768, 65535, 65535));
		send_box(make_req(0, 32767, 32767, 65535, 65535)); // wide right edge
		send_box(make_req(0, 5, 5, 0, 0));
		send_box(make_req(0, 5, 5, 0, 0));              // zero union against the last
		send_box(make_req(0, 32767, -1, 0, 65535));
		send_box(make_req(1, 0, 0, 160, 160));          // fresh frame, index back to 0
		send_box(make_req(0, 80, 0, 160, 160));         // IoU a third, keep
		send_box(make_req(0, 16, 0, 160, 160));         // high overlap, suppress
		send_box(make_req(0, 160, 0, 160, 160));        // touching the first box's edge only
		send_box(make_req(0, -1, -1, 65535, 65535));
		settle();
	endtask

	task automatic test_threshold_extremes();
		write_threshold(16'd0);
		send_box(make_req(1, 0, 0, 160, 160));
		send_box(make_req(0, 159, 159, 16, 16));        // one square unit of overlap
		send_box(make_req(0, 1000, 1000, 16, 16));
		send_box(make_req(0, 50, 50, 0, 16));
		settle();
		write_threshold(16'hFFFF);
		send_box(make_req(1, 0, 0, 160, 160));
		send_box(make_req(0, 0, 0, 160, 160));          // full overlap still beats max
		send_box(make_req(0, 16, 16, 128, 128));        // nested, IoU below one
		send_box(make_req(0, -32768, -32768, 65535, 65535));
		settle();
	endtask

	task automatic test_store_full();
		int i;
		write_threshold(THR_RESET);
		for (i = 0; i < MAX_KEPT + 6; i++)
			send_box(make_req(i == 0, (i % 10) * 400, (i / 10) * 400, 320, 320));
		// not stored, so cannot suppress; a stored one still can
		send_box(make_req(0, (65 % 10) * 400, (65 / 10) * 400, 320, 320));
		send_box(make_req(0, 3 * 400, 0, 320, 320));
		settle();
	endtask

	task automatic test_random_frames(input int n_items);
		int cx [40];
		int cy [40];
		int cw [40];
		int ch [40];
		int sent, frame_len, n_centres, c, i, pick;
		req_t r;
		sent = 0;
		while (sent < n_items) begin
			frame_len = ($urandom_range(0, 7) == 0) ? $urandom_range(65, 130)
				: $urandom_range(1, 40);
			n_centres = $urandom_range(1, 40);
			for (c = 0; c < n_centres; c++) begin
				cx[c] = int'($urandom_range(0, 8000)) - 4000;
				cy[c] = int'($urandom_range(0, 8000)) - 4000;
				cw[c] = $urandom_range(16, 1600);
				ch[c] = $urandom_range(16, 1600);
			end
			for (i = 0; i < frame_len && sent < n_items; i++) begin
				pick = $urandom_range(0, 19);
				c = $urandom_range(0, n_centres - 1);
				if (pick < 16) begin
					r = make_req(i == 0,
						cx[c] + int'($urandom_range(0, 128)) - 64,
						cy[c] + int'($urandom_range(0, 128)) - 64,
						cw[c] + int'($urandom_range(0, cw[c] / 4)) - cw[c] / 8,
						ch[c] + int'($urandom_range(0, ch[c] / 4)) - ch[c] / 8);
				end else if (pick < 18) begin
					r = make_req((i == 0) || ($urandom_range(0, 1) == 1),
						$urandom_range(0, 65535), $urandom_range(0, 65535),
						$urandom_range(0, 65535), $urandom_range(0, 65535));
				end else begin
					case ($urandom_range(0, 3))
						0: r = make_req(i == 0, cx[c], cy[c], 0, ch[c]);
						1: r = make_req(i == 0, cx[c], cy[c], cw[c], 0);
						2: r = make_req(i == 0, -32768, -32768, 65535, 65535);
						default: r = make_req(i == 0, 32767, 32767, 65535, 65535);
					endcase
				end
				send_box(r);
				sent++;
			end
		end
		settle();
	endtask

	// Result side: check each accepted result, then at times stall a while before the next
	initial begin : result_checker
		res_t want;
		int   n;
		result_stall <= 1'b0;
		forever begin
			do @(posedge clk); while (!(result_valid && !result_stall));
			if (verdict_q.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("unexpected result: keep=%0b index=%0d full=%0b",
						result.keep, result.box_index, result.store_full);
			end else begin
				want = verdict_q.pop_front();
				if (result.keep !== want.keep || result.box_index !== want.box_index ||
						result.store_full !== want.store_full) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("mismatch: want keep=%0b idx=%0d full=%0b, got %0b %0d %0b",
							want.keep, want.box_index, want.store_full,
							result.keep, result.box_index, result.store_full);
				end
			end
			n = draw_wait(rx_quiet);
			if (n > 0) begin
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// Abort if nothing moves on any channel for too long
	always @(posedge clk) begin
		if ((box_valid && !box_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready))
			stuck_cycles <= 0;
		else if (stuck_cycles >= STUCK_MAX) begin
			$display("FAIL");
			$finish;
		end else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin
		int p;
		fail_count   = 0;
		tx_quiet     = 0;
		rx_quiet     = 0;
		stuck_cycles = 0;
		held_n       = 0;
		next_index   = 0;
		thr_q16      = THR_RESET;
		arst_n    <= 1'b0;
		box_valid <= 1'b0;
		box       <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_threshold();
		test_threshold_extremes();
		test_store_full();
		for (p = 0; p < 5; p++) begin
			case (p)
				0: write_threshold(16'($urandom_range(0, 65535)));
				1: write_threshold(16'd0);
				2: write_threshold(16'hFFFF);
				3: write_threshold(THR_RESET);
				default: write_threshold(16'($urandom_range(0, 8000)));
			endcase
			test_random_frames(342);
		end

		repeat (END_PAUSE) @(posedge clk);
		if (verdict_q.size() != 0) begin
			fail_count++;
			$display("%0d results never arrived", verdict_q.size());
		end
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/gbs_pkg.sv
rtl/gbs_cell.sv
rtl/gbs_iou.sv
rtl/greedy_box_suppression.sv
tb/tb_greedy_box_suppression.sv
